// File: rtl/core/ccos_pkg.sv
// Package for the clamp close/open sequencer core.
// Holds word types, register indexes, phase codes and timing constants.
// No dependencies.
package ccos_pkg;

   localparam int MaxClamps = 100;
   localparam int SeqTickMs = 10;
   localparam int HeldMax = 60000;
   localparam int NumButtons = 3;

   localparam int CsrIndexW = 3;
   localparam int CsrDataW = 16;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_CLOSE_DELAY = 3'd0,
      CSR_OPEN_DELAY  = 3'd1,
      CSR_CLAMP_COUNT = 3'd2,
      CSR_SETTLE      = 3'd3,
      CSR_CMD_HOLD    = 3'd4,
      CSR_STOP_HOLD   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      BTN_IDLE    = 2'd0,
      BTN_SETTLE  = 2'd1,
      BTN_PRESSED = 2'd2
   } btn_phase_type;

   typedef enum logic [3:0] {
      SEQ_INIT        = 4'd0,
      SEQ_WAIT_START  = 4'd1,
      SEQ_FIRST_DELAY = 4'd2,
      SEQ_CLOSE       = 4'd3,
      SEQ_ARM         = 4'd4,
      SEQ_SPACING     = 4'd5,
      SEQ_CHECK       = 4'd6,
      SEQ_WAIT_OPEN   = 4'd7,
      SEQ_OPEN_DELAY  = 4'd8,
      SEQ_OPEN_ONE    = 4'd9,
      SEQ_DONE        = 4'd10
   } seq_phase_type;

   typedef struct packed {
      logic start_level;
      logic open_level;
      logic pause_level;
   } req_word_type;

   typedef struct packed {
      logic       clamp_event;
      logic [6:0] clamp_index;
      logic       clamp_on;
      logic       clear_all;
      logic [6:0] closed_count;
      logic       pause_active;
      logic [3:0] phase;
   } rsp_word_type;

endpackage

// File: rtl/core/ccos_chan_if.sv
// Valid/ready channel carrying one word of a given type.
// Used for the tick and result channels of the sequencer core.
interface ccos_chan_if #(
   parameter type word_type = logic
);
   logic     valid;
   logic     ready;
   word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

// File: rtl/core/clamp_close_open_sequencer_core.sv
// Top level of the clamp close/open sequencer: three debouncers and the phase sequencer.
// Depends on ccos_pkg and ccos_chan_if.
//
//   channel  dir  carries
//   req_if   in   one 1 ms tick word: raw start, open and pause levels (0 = pressed)
//   rsp_if   out  one result word per tick: clamp event, counts, pause, phase
//   csr_*    in   register write: enable, index, data
//
// One word per clock sustained while the result register is not stalled; each tick
// forms its state update and result while it sits in the input register, and then
// sits in the result register.
// A stalled result register holds the input register, which then drops ready.
// Synchronous reset clears all sequencer and debouncer state and loads register defaults.
module clamp_close_open_sequencer_core (
   input  logic                              clock,
   input  logic                              reset,
   ccos_chan_if.sink                         req_if,
   ccos_chan_if.source                       rsp_if,
   input  logic                              csr_wr_en,
   input  logic [ccos_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [ccos_pkg::CsrDataW-1:0]     csr_wdata
);
   import ccos_pkg::*;

   logic [14:0] close_gap_ff;
   logic [14:0] open_gap_ff;
   logic [6:0]  clamp_count_ff;
   logic [7:0]  settle_ff;
   logic [15:0] cmd_hold_ff;
   logic [15:0] stop_hold_ff;

   logic          in_valid_ff;
   req_word_type  in_word_ff;
   logic          out_valid_ff;
   rsp_word_type  out_word_ff;
   logic          advance;

   logic [31:0]   now_ff;
   btn_phase_type btn_phase_ff [NumButtons];
   btn_phase_type btn_phase_in [NumButtons];
   logic [31:0]   press_stamp_ff [NumButtons];
   logic [31:0]   press_stamp_in [NumButtons];
   logic [15:0]   held [NumButtons];
   logic          level [NumButtons];
   logic [31:0]   btn_diff [NumButtons];

   seq_phase_type seq_phase_ff;
   seq_phase_type seq_phase_in;
   logic [6:0]    closed_ff;
   logic [6:0]    closed_in;
   logic [31:0]   phase_stamp_ff;
   logic [31:0]   phase_stamp_in;
   logic [31:0]   slow_stamp_ff;
   logic [31:0]   slow_stamp_in;

   logic          step;
   logic          start_hit;
   logic          open_hit;
   logic          stop_hit;
   logic          pause_hit;
   logic [31:0]   spacing_stamp;
   logic          close_expired;
   logic          spacing_expired;
   logic          open_expired;
   logic [6:0]    eff_count;
   logic [6:0]    closed_inc;
   logic          ev;
   logic [6:0]    idx;
   logic          on;
   logic          clr;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         close_gap_ff   <= 15'd200;
         open_gap_ff    <= 15'd100;
         clamp_count_ff <= 7'd100;
         settle_ff      <= 8'd3;
         cmd_hold_ff    <= 16'd100;
         stop_hold_ff   <= 16'd2000;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CLOSE_DELAY: close_gap_ff   <= csr_wdata[14:0];
            CSR_OPEN_DELAY:  open_gap_ff    <= csr_wdata[14:0];
            CSR_CLAMP_COUNT: clamp_count_ff <= csr_wdata[6:0];
            CSR_SETTLE:      settle_ff      <= csr_wdata[7:0];
            CSR_CMD_HOLD:    cmd_hold_ff    <= csr_wdata;
            CSR_STOP_HOLD:   stop_hold_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;
   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.word  = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_if.ready) in_valid_ff <= req_if.valid;
         if (advance) out_valid_ff <= 1'b1;
         else if (rsp_if.ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) in_word_ff <= req_if.word;
   end

   // debouncers
   assign level[0] = in_word_ff.start_level;
   assign level[1] = in_word_ff.open_level;
   assign level[2] = in_word_ff.pause_level;

   always_comb begin
      for (int b = 0; b < NumButtons; b++) begin
         btn_diff[b]       = now_ff - press_stamp_ff[b];
         btn_phase_in[b]   = btn_phase_ff[b];
         press_stamp_in[b] = press_stamp_ff[b];
         held[b]           = 16'd0;
         case (btn_phase_ff[b])
            BTN_IDLE: begin
               if (!level[b]) begin
                  press_stamp_in[b] = now_ff;
                  btn_phase_in[b]   = BTN_SETTLE;
               end
            end
            BTN_SETTLE: begin
               if (btn_diff[b] >= {24'd0, settle_ff}) btn_phase_in[b] = BTN_PRESSED;
            end
            BTN_PRESSED: begin
               if (!level[b]) begin
                  if (btn_diff[b] >= 32'(HeldMax)) begin
                     press_stamp_in[b] = now_ff - 32'(HeldMax);
                     held[b]           = 16'(HeldMax);
                  end else begin
                     held[b] = btn_diff[b][15:0];
                  end
               end else begin
                  btn_phase_in[b] = BTN_IDLE;
               end
            end
            default: btn_phase_in[b] = BTN_IDLE;
         endcase
      end
   end

   // sequencer conditions
   assign step            = (now_ff - slow_stamp_ff) >= 32'(SeqTickMs);
   assign start_hit       = held[0] >= cmd_hold_ff;
   assign open_hit        = held[1] >= cmd_hold_ff;
   assign stop_hit        = held[1] >= stop_hold_ff;
   assign pause_hit       = held[2] >= cmd_hold_ff;
   assign spacing_stamp   = pause_hit ? now_ff : phase_stamp_ff;
   assign close_expired   = (now_ff - phase_stamp_ff) >= {17'd0, close_gap_ff};
   assign spacing_expired = (now_ff - spacing_stamp) >= {17'd0, close_gap_ff};
   assign open_expired    = (now_ff - phase_stamp_ff) >= {17'd0, open_gap_ff};
   assign closed_inc      = closed_ff + 7'd1;

   always_comb begin
      if (32'(clamp_count_ff) > 32'(MaxClamps)) eff_count = 7'(MaxClamps);
      else if (clamp_count_ff == 7'd0) eff_count = 7'd1;
      else eff_count = clamp_count_ff;
   end

   // next state
   always_comb begin
      seq_phase_in = seq_phase_ff;
      if (step) begin
         case (seq_phase_ff)
            SEQ_INIT:        seq_phase_in = SEQ_WAIT_START;
            SEQ_WAIT_START:  if (start_hit) seq_phase_in = SEQ_FIRST_DELAY;
            SEQ_FIRST_DELAY: if (close_expired) seq_phase_in = SEQ_CLOSE;
            SEQ_CLOSE:       seq_phase_in = SEQ_ARM;
            SEQ_ARM:         seq_phase_in = SEQ_SPACING;
            SEQ_SPACING: begin
               if (stop_hit) seq_phase_in = SEQ_OPEN_ONE;
               else if (spacing_expired) seq_phase_in = SEQ_CHECK;
            end
            SEQ_CHECK: begin
               if (closed_ff >= eff_count) seq_phase_in = SEQ_WAIT_OPEN;
               else seq_phase_in = SEQ_CLOSE;
            end
            SEQ_WAIT_OPEN:   if (open_hit) seq_phase_in = SEQ_OPEN_DELAY;
            SEQ_OPEN_DELAY:  if (open_expired) seq_phase_in = SEQ_OPEN_ONE;
            SEQ_OPEN_ONE: begin
               if (closed_ff != 7'd0) seq_phase_in = SEQ_OPEN_DELAY;
               else seq_phase_in = SEQ_DONE;
            end
            default:         seq_phase_in = SEQ_INIT;
         endcase
      end
   end

   // outputs and datapath updates
   always_comb begin
      ev             = 1'b0;
      idx            = 7'd0;
      on             = 1'b0;
      clr            = 1'b0;
      closed_in      = closed_ff;
      phase_stamp_in = phase_stamp_ff;
      slow_stamp_in  = slow_stamp_ff;
      if (step) begin
         slow_stamp_in = now_ff;
         case (seq_phase_ff)
            SEQ_INIT: begin
               clr       = 1'b1;
               closed_in = 7'd0;
            end
            SEQ_WAIT_START:  if (start_hit) phase_stamp_in = now_ff;
            SEQ_FIRST_DELAY: if (close_expired) phase_stamp_in = now_ff;
            SEQ_CLOSE: begin
               ev  = 1'b1;
               idx = closed_ff;
               on  = 1'b1;
            end
            SEQ_ARM:         phase_stamp_in = now_ff;
            SEQ_SPACING: begin
               phase_stamp_in = spacing_stamp;
               if (spacing_expired) closed_in = closed_inc;
            end
            SEQ_CHECK:       if (closed_ff >= eff_count) closed_in = eff_count;
            SEQ_WAIT_OPEN:   if (open_hit) phase_stamp_in = now_ff;
            SEQ_OPEN_ONE: begin
               if (closed_ff != 7'd0) begin
                  closed_in      = closed_ff - 7'd1;
                  ev             = 1'b1;
                  idx            = closed_ff - 7'd1;
                  phase_stamp_in = now_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // state update, one tick per advance
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff         <= 32'd0;
         seq_phase_ff   <= SEQ_INIT;
         closed_ff      <= 7'd0;
         phase_stamp_ff <= 32'd0;
         slow_stamp_ff  <= 32'd0;
         for (int b = 0; b < NumButtons; b++) begin
            btn_phase_ff[b]   <= BTN_IDLE;
            press_stamp_ff[b] <= 32'd0;
         end
      end else if (advance) begin
         now_ff         <= now_ff + 32'd1;
         seq_phase_ff   <= seq_phase_in;
         closed_ff      <= closed_in;
         phase_stamp_ff <= phase_stamp_in;
         slow_stamp_ff  <= slow_stamp_in;
         for (int b = 0; b < NumButtons; b++) begin
            btn_phase_ff[b]   <= btn_phase_in[b];
            press_stamp_ff[b] <= press_stamp_in[b];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff.clamp_event  <= ev;
         out_word_ff.clamp_index  <= idx;
         out_word_ff.clamp_on     <= on;
         out_word_ff.clear_all    <= clr;
         out_word_ff.closed_count <= closed_in;
         out_word_ff.pause_active <= pause_hit;
         out_word_ff.phase        <= 4'(seq_phase_in);
      end
   end

`ifndef SYNTHESIS
   a_close_event_arms: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.clamp_event && out_word_ff.clamp_on)
         |-> (out_word_ff.phase == 4'(SEQ_ARM)))
      else $error("closing event outside arm phase");

   a_open_event_waits: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.clamp_event && !out_word_ff.clamp_on)
         |-> (out_word_ff.phase == 4'(SEQ_OPEN_DELAY)))
      else $error("opening event outside open delay phase");

   a_clear_restarts: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_word_ff.clear_all)
         |-> (out_word_ff.closed_count == 7'd0 && out_word_ff.phase == 4'(SEQ_WAIT_START)))
      else $error("clear without restart");

   a_held_saturates: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> (held[0] <= 16'(HeldMax) && held[1] <= 16'(HeldMax)
         && held[2] <= 16'(HeldMax)))
      else $error("held time above saturation");

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      advance |=> (now_ff == $past(now_ff) + 32'd1))
      else $error("tick time did not advance");
`endif

endmodule
